/* rtl/core/bmf_pkg.sv */
// bmf_pkg: shared types and constants for the box mean filter.
// Holds the command word passed from front end to back end, the queue status
// group and the register indexes. No dependencies.
package bmf_pkg;

   localparam int PixelWidth   = 16;
   localparam int CoordWidth   = 9;   // row/col plus half width, and dimension counts
   localparam int FilterWidth  = 4;
   localparam int CsrIdxWidth  = 2;
   localparam int CsrDataWidth = 9;

   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_ROWS  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_IMAGE_COLS  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_FILTER_SIZE = 2'd2;

   localparam int FifoDepth    = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);
   localparam int FifoCntWidth = $clog2(FifoDepth + 1);

   typedef enum logic [1:0] {
      OP_STORE,
      OP_READ,
      OP_BAD
   } op_type;

   // store: r_lo/c_lo carry the address; read: the cropped window bounds
   typedef struct packed {
      op_type                  op;
      logic [CoordWidth-1:0]   r_lo;
      logic [CoordWidth-1:0]   r_hi;
      logic [CoordWidth-1:0]   c_lo;
      logic [CoordWidth-1:0]   c_hi;
      logic [PixelWidth-1:0]   pixel;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

/* rtl/core/bmf_front.sv */
// bmf_front: configuration registers and classification of incoming words.
// Clamps the image size and window, works out the cropped window bounds.
// Depends on bmf_pkg.
module bmf_front #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int MAX_FILTER = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bmf_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [bmf_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [7:0]                        req_row,
   input  logic [7:0]                        req_col,
   input  logic [bmf_pkg::PixelWidth-1:0]    req_pixel_value,
   input  bmf_pkg::fifo_stat_type            q_stat,
   output logic                              q_push,
   output bmf_pkg::cmd_type                  q_cmd
);
   import bmf_pkg::*;

   logic [CoordWidth-1:0]  rows_ff, cols_ff;
   logic [FilterWidth-1:0] fsize_ff;
   logic [CoordWidth-1:0]  nrows, ncols, row9, col9, half9;
   logic [CoordWidth-1:0]  r_up, c_up;
   logic [FilterWidth-1:0] fs;
   logic                   in_img;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= CoordWidth'(256);
         cols_ff  <= CoordWidth'(256);
         fsize_ff <= FilterWidth'(3);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_ROWS:  rows_ff  <= csr_wdata;
            CSR_IMAGE_COLS:  cols_ff  <= csr_wdata;
            CSR_FILTER_SIZE: fsize_ff <= csr_wdata[FilterWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // zero acts as one, above the maximum saturates
      if (rows_ff == '0)
         nrows = CoordWidth'(1);
      else if (32'(rows_ff) > MAX_ROWS)
         nrows = CoordWidth'(MAX_ROWS);
      else
         nrows = rows_ff;
      if (cols_ff == '0)
         ncols = CoordWidth'(1);
      else if (32'(cols_ff) > MAX_COLS)
         ncols = CoordWidth'(MAX_COLS);
      else
         ncols = cols_ff;
      fs    = (32'(fsize_ff) > MAX_FILTER) ? FilterWidth'(MAX_FILTER) : fsize_ff;
      half9 = CoordWidth'(fs >> 1);
      row9  = CoordWidth'(req_row);
      col9  = CoordWidth'(req_col);
      in_img = (row9 < nrows) && (col9 < ncols);
      r_up  = row9 + half9;
      c_up  = col9 + half9;

      q_cmd.pixel = req_pixel_value;
      q_cmd.r_lo  = (row9 >= half9) ? row9 - half9 : '0;
      q_cmd.c_lo  = (col9 >= half9) ? col9 - half9 : '0;
      q_cmd.r_hi  = (r_up > nrows - 1'b1) ? nrows - 1'b1 : r_up;
      q_cmd.c_hi  = (c_up > ncols - 1'b1) ? ncols - 1'b1 : c_up;
      if (!req_action) begin
         q_cmd.op   = OP_STORE;
         q_cmd.r_lo = row9;
         q_cmd.c_lo = col9;
      end else if (in_img) begin
         q_cmd.op = OP_READ;
      end else begin
         q_cmd.op = OP_BAD;
      end
   end

   // stores outside the image are taken and dropped
   assign req_ready = !q_stat.full;
   assign q_push    = req_valid && !q_stat.full && (req_action || in_img);

endmodule

/* rtl/core/bmf_fifo.sv */
// bmf_fifo: short command queue between front end and back end.
// Depends on bmf_pkg.
module bmf_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bmf_pkg::cmd_type       push_cmd,
   input  logic                   pop,
   output bmf_pkg::cmd_type       pop_cmd,
   output bmf_pkg::fifo_stat_type stat
);
   import bmf_pkg::*;

   cmd_type                  slot_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FifoCntWidth-1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)
            cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push)
            cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_cmd;
   end

   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == FifoCntWidth'(FifoDepth));
   assign stat.empty = (cnt_ff == '0);

endmodule

/* rtl/core/bmf_div.sv */
// bmf_div: restoring divider, one quotient bit per cycle.
// Quotient is known to fit in PixelWidth bits. Depends on bmf_pkg.
module bmf_div #(
   parameter int DIVISOR_W = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  logic [DIVISOR_W+bmf_pkg::PixelWidth-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]                       divisor,
   output logic                                       done,
   output logic [bmf_pkg::PixelWidth-1:0]             quotient
);
   import bmf_pkg::*;

   localparam int StepWidth = $clog2(PixelWidth + 1);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [PixelWidth-1:0] sh_ff, sh_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic [DIVISOR_W:0]    trial, diff;
   logic                  ge;

   always_comb begin
      trial   = {rem_ff, sh_ff[PixelWidth-1]};
      diff    = trial - {1'b0, divisor};
      ge      = (trial >= {1'b0, divisor});
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend[DIVISOR_W+PixelWidth-1:PixelWidth];
         sh_in   = dividend[PixelWidth-1:0];
         step_in = StepWidth'(PixelWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         sh_in   = {sh_ff[PixelWidth-2:0], ge};
         step_in = step_ff - 1'b1;
         busy_in = (step_ff != StepWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         busy_ff <= 1'b0;
      else
         busy_ff <= busy_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      step_ff <= step_in;
   end

   assign done     = busy_ff && (step_ff == StepWidth'(1));
   assign quotient = sh_ff;

endmodule

/* rtl/core/bmf_back.sv */
// bmf_back: pixel memory, window walk, accumulation and the result register.
// Uses bmf_div for the rounding division. Depends on bmf_pkg.
module bmf_back #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int MAX_FILTER = 15
) (
   input  logic                            clock,
   input  logic                            reset,
   input  bmf_pkg::fifo_stat_type          q_stat,
   input  bmf_pkg::cmd_type                q_cmd,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bmf_pkg::PixelWidth-1:0]  rsp_mean_value,
   output logic                            rsp_bad_address
);
   import bmf_pkg::*;

   localparam int RowBits  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int ColBits  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AddrBits = RowBits + ColBits;
   localparam int Depth    = MAX_ROWS * (2 ** ColBits);
   localparam int WinMax   = 2 * (MAX_FILTER / 2) + 1;
   localparam int CntBits  = $clog2(WinMax * WinMax + 1);
   localparam int SumBits  = PixelWidth + CntBits;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   state_type              state_ff, state_in;
   logic [CoordWidth-1:0]  cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [CoordWidth-1:0]  c_lo_ff, c_lo_in, r_hi_ff, r_hi_in, c_hi_ff, c_hi_in;
   logic [SumBits-1:0]     sum_ff, sum_in;
   logic [CntBits-1:0]     cnt_ff, cnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   bad_ff, bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PixelWidth-1:0]  rsp_mean_ff, rsp_mean_in;
   logic                   rsp_bad_ff, rsp_bad_in;

   logic [PixelWidth-1:0]  mem [Depth];
   logic [PixelWidth-1:0]  rdata_ff;
   logic                   mem_we, rd_en;
   logic [AddrBits-1:0]    waddr, raddr;
   logic [RowBits+CoordWidth-1:0] wr_row_w, rd_row_w;
   logic [ColBits+CoordWidth-1:0] wr_col_w, rd_col_w;

   logic                   div_start, div_done;
   logic [SumBits-1:0]     dividend;
   logic [PixelWidth-1:0]  quotient;

   // row-major address, column field padded to a power of two
   always_comb begin
      wr_row_w = (RowBits + CoordWidth)'(q_cmd.r_lo);
      wr_col_w = (ColBits + CoordWidth)'(q_cmd.c_lo);
      rd_row_w = (RowBits + CoordWidth)'(cur_r_ff);
      rd_col_w = (ColBits + CoordWidth)'(cur_c_ff);
      waddr    = {wr_row_w[RowBits-1:0], wr_col_w[ColBits-1:0]};
      raddr    = {rd_row_w[RowBits-1:0], rd_col_w[ColBits-1:0]};
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[waddr] <= q_cmd.pixel;
      if (rd_en)
         rdata_ff <= mem[raddr];
   end

   // round to nearest: (sum + count/2) / count
   assign dividend = sum_ff + SumBits'(cnt_ff >> 1);

   bmf_div #(
      .DIVISOR_W (CntBits)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      c_lo_in      = c_lo_ff;
      r_hi_in      = r_hi_ff;
      c_hi_in      = c_hi_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_bad_in   = rsp_bad_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;

      // read data lands in the cycle after its address
      if (rd_pend_ff)
         sum_in = sum_ff + SumBits'(rdata_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop = 1'b1;
               unique case (q_cmd.op)
                  OP_STORE: mem_we = 1'b1;
                  OP_READ: begin
                     cur_r_in = q_cmd.r_lo;
                     cur_c_in = q_cmd.c_lo;
                     c_lo_in  = q_cmd.c_lo;
                     r_hi_in  = q_cmd.r_hi;
                     c_hi_in  = q_cmd.c_hi;
                     sum_in   = '0;
                     cnt_in   = '0;
                     bad_in   = 1'b0;
                     state_in = ST_WALK;
                  end
                  OP_BAD: begin
                     bad_in   = 1'b1;
                     state_in = ST_RESULT;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            rd_en      = 1'b1;
            rd_pend_in = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cur_c_ff == c_hi_ff) begin
               cur_c_in = c_lo_ff;
               if (cur_r_ff == r_hi_ff)
                  state_in = ST_DRAIN;
               else
                  cur_r_in = cur_r_ff + 1'b1;
            end else begin
               cur_c_in = cur_c_ff + 1'b1;
            end
         end
         ST_DRAIN:  state_in = ST_LAUNCH;
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done)
               state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = bad_ff ? '0 : quotient;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      c_lo_ff     <= c_lo_in;
      r_hi_ff     <= r_hi_in;
      c_hi_ff     <= c_hi_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      bad_ff      <= bad_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_bad_address = rsp_bad_ff;

endmodule

/* rtl/core/box_mean_filter_cropped.sv */
// box_mean_filter_cropped: top level of the box mean filter image store.
// Instantiates bmf_front, bmf_fifo and bmf_back; depends on bmf_pkg.
//
// Use:
//  - req_ channel (valid/ready): action 0 stores pixel_value at (row, col),
//    action 1 asks for the mean of the cropped square window round (row, col).
//    Stores outside the configured image are taken and dropped.
//  - rsp_ channel (valid/ready): one word per read; bad_address set (and
//    mean_value zero) when the read lies outside the configured image.
//  - csr_ port: image_rows (0), image_cols (1), window size (2); write only
//    while the block is idle. Other indexes are ignored.
// Timing: a word enters the four-deep command queue the cycle it is taken.
//  The back end writes a store from its idle state; for a read it walks the
//  pixels inside the cropped window one at a time on the single memory read
//  port, then divides in the bit-serial divider. Reads outside the image skip
//  the walk and the divide.
// Reset: clears control state and the queue; the pixel memory is not
//  cleared, so a window must only cover pixels already written.
// Stall: the result register holds its word while rsp_ready is low; the
//  back end then waits with its next result while the queue keeps taking
//  words until it is full.
module box_mean_filter_cropped #(
   parameter int MAX_ROWS   = 256,
   parameter int MAX_COLS   = 256,
   parameter int MAX_FILTER = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [bmf_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [bmf_pkg::CsrDataWidth-1:0]  csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [7:0]                        req_row,
   input  logic [7:0]                        req_col,
   input  logic [bmf_pkg::PixelWidth-1:0]    req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bmf_pkg::PixelWidth-1:0]    rsp_mean_value,
   output logic                              rsp_bad_address
);
   import bmf_pkg::*;

   fifo_stat_type q_stat;
   cmd_type       push_cmd, pop_cmd;
   logic          q_push, q_pop;

   // front end: registers and classification
   bmf_front #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_FILTER (MAX_FILTER)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel_value (req_pixel_value),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   // decouples the two halves
   bmf_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .stat     (q_stat)
   );

   // back end: memory, window walk, divide, result register
   bmf_back #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_FILTER (MAX_FILTER)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_bad_address (rsp_bad_address)
   );

   // a flagged read never carries a mean
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_address |-> rsp_mean_value == '0)
      else $error("bad address word with non-zero mean");

   // back end only pops a queue that holds something
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty command queue");

   // queue never written while full
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("push into full command queue");

   // no result word straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

/* tb/tb_box_mean_filter_cropped.sv */
// tb_box_mean_filter_cropped: self-checking bench for the box mean filter image store.
// Drives store/read words with random gaps, predicts each window mean and checks every result.
// Depends on bmf_pkg and box_mean_filter_cropped.
module tb_box_mean_filter_cropped;

   import bmf_pkg::*;

   localparam int IMG_MAX    = 256;   // matches MAX_ROWS / MAX_COLS of the instance
   localparam int FILTER_MAX = 15;
   localparam int IDLE_LIMIT = 4000;  // cycles with no word taken on either side
   localparam int HOLD_LEN   = 300;   // the one long back-pressure stretch
   localparam logic [CsrIdxWidth-1:0] CSR_SPARE = 2'd3;  // decoded by nobody

   typedef enum logic {
      ACT_STORE = 1'b0,
      ACT_READ  = 1'b1
   } act_e;

   typedef struct packed {
      act_e                  action;
      logic [7:0]            row;
      logic [7:0]            col;
      logic [PixelWidth-1:0] pixel;
   } pixel_cmd_t;

   typedef struct packed {
      logic [PixelWidth-1:0] mean;
      logic                  bad;
   } mean_word_t;

   // ports
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_en = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_action = 1'b0;
   logic [7:0]              req_row = '0;
   logic [7:0]              req_col = '0;
   logic [PixelWidth-1:0]   req_pixel_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PixelWidth-1:0]   rsp_mean_value;
   logic                    rsp_bad_address;

   // shadow of the block: registers as written, and the pixel memory
   logic [CsrDataWidth-1:0] cfg_rows  = 9'd256;
   logic [CsrDataWidth-1:0] cfg_cols  = 9'd256;
   logic [FilterWidth-1:0]  cfg_fsize = 4'd3;
   logic [PixelWidth-1:0]   shadow_pix [0:IMG_MAX*IMG_MAX-1];

   // stimulus bookkeeping: which pixels the queued stores will have written
   bit                      filled [0:IMG_MAX*IMG_MAX-1];
   int                      gen_count = 0;

   pixel_cmd_t              pixel_cmds[$];     // words waiting to be offered
   mean_word_t              awaited_means[$];  // predicted results, oldest first
   pixel_cmd_t              next_cmd;
   mean_word_t              want;

   bit                      req_took = 1'b0;
   bit                      rsp_took = 1'b0;
   bit                      src_calm = 1'b0;
   bit                      sink_calm = 1'b0;
   bit                      hold_done = 1'b0;
   int                      src_gap = 0;
   int                      sink_gap = 0;
   int                      hold_left = 0;
   int                      means_seen = 0;
   int                      mismatches = 0;
   int                      idle_cycles = 0;

   box_mean_filter_cropped dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_row         (req_row),
      .req_col         (req_col),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_bad_address (rsp_bad_address)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow model
   // ---------------------------------------------------------------------

   // zero counts act as one, anything past the array saturates
   function automatic int eff_dim(logic [CsrDataWidth-1:0] v);
      if (v == 0) return 1;
      if (v > IMG_MAX) return IMG_MAX;
      return v;
   endfunction

   // even sizes round down to the same half width as the next odd size;
   // the 4-bit register cannot exceed FILTER_MAX, clamp kept for safety
   function automatic int half_width();
      int fs;
      fs = cfg_fsize;
      if (fs > FILTER_MAX) fs = FILTER_MAX;
      return fs / 2;
   endfunction

   function automatic bit in_image(int r, int c);
      return r >= 0 && c >= 0 && r < eff_dim(cfg_rows) && c < eff_dim(cfg_cols);
   endfunction

   // cropped box mean, rounded to nearest with ties upwards
   function automatic mean_word_t window_mean_of(logic [7:0] row, logic [7:0] col);
      mean_word_t  res;
      int          r0, c0, half, r, c;
      int unsigned sum, count;
      r0 = row;
      c0 = col;
      res.mean = '0;
      res.bad = 1'b0;
      sum = 0;
      count = 0;
      if (!in_image(r0, c0)) begin
         res.bad = 1'b1;
         return res;
      end
      half = half_width();
      for (r = r0 - half; r <= r0 + half; r++) begin
         for (c = c0 - half; c <= c0 + half; c++) begin
            if (in_image(r, c)) begin
               sum += shadow_pix[r * IMG_MAX + c];
               count++;
            end
         end
      end
      res.mean = PixelWidth'((sum + count / 2) / count);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic int gap_length(bit calm);
      int p;
      if (calm) return 0;
      p = $urandom_range(99);
      if (p < 55) return 0;
      if (p < 88) return $urandom_range(3, 1);
      if (p < 97) return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   // big images: stay near the corners so windows get filled quickly
   function automatic logic [7:0] near_coord(int n);
      if (n <= 24) return 8'($urandom_range(n - 1, 0));
      if ($urandom_range(1)) return 8'($urandom_range(15, 0));
      return 8'($urandom_range(n - 1, n - 16));
   endfunction

   // a point outside the configured image; 0 when the image is full size
   function automatic bit outside_point(output logic [7:0] r, output logic [7:0] c);
      int nr, nc;
      nr = eff_dim(cfg_rows);
      nc = eff_dim(cfg_cols);
      r = 8'($urandom);
      c = 8'($urandom);
      if (nr == IMG_MAX && nc == IMG_MAX) return 1'b0;
      if (nc == IMG_MAX || (nr < IMG_MAX && $urandom_range(1)))
         r = 8'($urandom_range(IMG_MAX - 1, nr));
      else
         c = 8'($urandom_range(IMG_MAX - 1, nc));
      return 1'b1;
   endfunction

   task automatic push_store(logic [7:0] row, logic [7:0] col, logic [PixelWidth-1:0] pix);
      pixel_cmd_t cmd;
      cmd.action = ACT_STORE;
      cmd.row = row;
      cmd.col = col;
      cmd.pixel = pix;
      pixel_cmds.push_back(cmd);
      // stores off the image are dropped by the block and do not count
      if (in_image(row, col)) begin
         filled[{row, col}] = 1'b1;
         gen_count++;
      end
   endtask

   // a read is preceded by stores to any pixel of its window not yet written
   task automatic push_read(logic [7:0] row, logic [7:0] col);
      pixel_cmd_t cmd;
      int         r0, c0, half, r, c;
      r0 = row;
      c0 = col;
      if (in_image(r0, c0)) begin
         half = half_width();
         for (r = r0 - half; r <= r0 + half; r++)
            for (c = c0 - half; c <= c0 + half; c++)
               if (in_image(r, c) && !filled[r * IMG_MAX + c])
                  push_store(8'(r), 8'(c), PixelWidth'($urandom));
      end
      cmd.action = ACT_READ;
      cmd.row = row;
      cmd.col = col;
      cmd.pixel = PixelWidth'($urandom);
      pixel_cmds.push_back(cmd);
      gen_count++;
   endtask

   // wait for the block to drain: everything offered, taken and answered,
   // then a margin for trailing stores still in the command queue
   task automatic settle(int tail);
      while (pixel_cmds.size() != 0 || req_valid || awaited_means.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic set_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
      settle(24);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_IMAGE_ROWS:  cfg_rows = val;
         CSR_IMAGE_COLS:  cfg_cols = val;
         CSR_FILTER_SIZE: cfg_fsize = val[FilterWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(int rows, int cols, int fsize);
      set_reg(CSR_IMAGE_ROWS, CsrDataWidth'(rows));
      set_reg(CSR_IMAGE_COLS, CsrDataWidth'(cols));
      set_reg(CSR_FILTER_SIZE, CsrDataWidth'(fsize));
   endtask

   // mostly reads of filled windows, some overwrites, some off-image words
   task automatic run_phase(int rows, int cols, int fsize, int n_items);
      int         stop_at, pick;
      logic [7:0] r, c;
      set_config(rows, cols, fsize);
      stop_at = gen_count + n_items;
      while (gen_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick >= 80 && outside_point(r, c)) begin
            if (pick < 90) push_store(r, c, PixelWidth'($urandom));
            else push_read(r, c);
         end else begin
            r = near_coord(eff_dim(cfg_rows));
            c = near_coord(eff_dim(cfg_cols));
            if (pick < 55) push_read(r, c);
            else push_store(r, c, PixelWidth'($urandom));
         end
      end
   endtask

   task automatic log_fault(string text);
      mismatches++;
      if (mismatches <= 10) $display("%s", text);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued words at the falling edge, gaps after each take
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_took) begin
            if ($urandom_range(49) == 0) src_calm = !src_calm;
            src_gap = gap_length(src_calm);
         end
         if (src_gap > 0) begin
            src_gap--;
            req_valid <= 1'b0;
         end else if (pixel_cmds.size() != 0) begin
            next_cmd = pixel_cmds.pop_front();
            req_valid       <= 1'b1;
            req_action      <= next_cmd.action;
            req_row         <= next_cmd.row;
            req_col         <= next_cmd.col;
            req_pixel_value <= next_cmd.pixel;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result sink: random stalls, plus one long hold-off once results flow
   // so that the command queue fills and req_ready drops
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && means_seen >= 30) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(39) == 0) sink_calm = !sink_calm;
            sink_gap = gap_length(sink_calm);
         end
         if (sink_gap > 0) begin
            sink_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: at the rising edge, predict taken words, check taken results,
   // and watch for a hang
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      req_took = !reset && req_valid && req_ready;
      rsp_took = !reset && rsp_valid && rsp_ready;
      if (req_took) begin
         if (req_action == ACT_STORE) begin
            if (in_image(req_row, req_col)) shadow_pix[{req_row, req_col}] = req_pixel_value;
         end else begin
            awaited_means.push_back(window_mean_of(req_row, req_col));
         end
      end
      if (rsp_took) begin
         means_seen++;
         if (awaited_means.size() == 0) begin
            log_fault($sformatf("result with none outstanding: mean %h bad %b",
                                rsp_mean_value, rsp_bad_address));
         end else begin
            want = awaited_means.pop_front();
            if (rsp_mean_value !== want.mean || rsp_bad_address !== want.bad)
               log_fault($sformatf("result %0d: mean exp %h got %h, bad exp %b got %b",
                                   means_seen, want.mean, rsp_mean_value,
                                   want.bad, rsp_bad_address));
         end
      end
      if (req_took || rsp_took) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("box_mean_filter_cropped test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset settings: 256 x 256, 3x3 window
      // top-left corner, window cropped to 2x2 of full-scale pixels
      push_store(8'd0, 8'd0, 16'hFFFF);
      push_store(8'd0, 8'd1, 16'hFFFF);
      push_store(8'd1, 8'd0, 16'hFFFF);
      push_store(8'd1, 8'd1, 16'hFFFF);
      push_read(8'd0, 8'd0);
      // bottom-right corner, mean of exactly one half: tie rounds up
      push_store(8'd255, 8'd255, 16'h0000);
      push_store(8'd255, 8'd254, 16'h0001);
      push_store(8'd254, 8'd255, 16'h0000);
      push_store(8'd254, 8'd254, 16'h0001);
      push_read(8'd255, 8'd255);

      // zero rows act as one, oversize columns saturate, filter size zero
      set_config(0, 511, 0);
      push_store(8'd0, 8'd200, 16'h8000);
      push_store(8'd3, 8'd10, 16'h1234);   // off the image, dropped
      push_read(8'd0, 8'd200);
      push_read(8'd3, 8'd10);              // off the image, flagged
      push_read(8'd0, 8'd255);
      // write to an undecoded index must leave the settings alone
      set_reg(CSR_SPARE, 9'h1FF);
      push_read(8'd0, 8'd200);
      push_read(8'd1, 8'd0);

      run_phase(8, 8, 3, 90);
      run_phase(16, 16, 2, 80);
      run_phase(1, 256, 15, 60);
      run_phase(256, 1, 5, 50);
      run_phase(6, 9, 15, 50);
      run_phase(256, 256, 1, 80);
      run_phase(5, 7, 4, 60);
      run_phase(511, 300, 3, 60);
      run_phase(0, 0, 14, 30);
      run_phase(10, 3, 7, 50);
      run_phase(3, 256, 9, 40);
      run_phase(256, 256, 0, 50);

      settle(64);
      if (mismatches == 0)
         $display("box_mean_filter_cropped test passed");
      else
         $display("box_mean_filter_cropped test failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/bmf_pkg.sv
rtl/core/bmf_front.sv
rtl/core/bmf_fifo.sv
rtl/core/bmf_div.sv
rtl/core/bmf_back.sv
rtl/core/box_mean_filter_cropped.sv
tb/tb_box_mean_filter_cropped.sv
